// ----- hdl/pareto_filter_table_assert.svh -----
// Assertion macros shared by the checker of the filter table.
// No dependencies; included by the files that hold assertions.
`ifndef PARETO_FILTER_TABLE_ASSERT_SVH
`define PARETO_FILTER_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pft_pkg.sv -----
// Types and constants of the filter table: opcodes, CSR indexes, field widths
// and the command bundle from controller to datapath. No dependencies.
package pft_pkg;

   localparam int VIOL_W     = 32;
   localparam int OBJ_W      = 48;
   localparam int GAMMA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_QUERY   = 2'd1,
      OP_AUGMENT = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_THETA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_F     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TINY_VIOL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VIOL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_OBJ    = 3'd4;

   // Reset values of the configuration registers
   localparam logic [GAMMA_W-1:0] GAMMA_RESET     = 16'd66;
   localparam logic [VIOL_W-1:0]  TINY_RESET      = 32'd0;
   localparam logic [VIOL_W-1:0]  INIT_VIOL_RESET = 32'hFFFF_FFFF;
   localparam logic [OBJ_W-1:0]   INIT_OBJ_RESET  = {1'b1, {(OBJ_W-1){1'b0}}};

   // Per-cycle commands from the controller
   typedef struct packed {
      logic load;      // capture the transaction's fields, clear flags
      logic prep_mul;  // multiply the trial violation by both factors
      logic prep_sat;  // form the shrunk pair
      logic rd_en;     // read one table entry
      logic init;      // empty the table and store the initial pair
      logic insert;    // store the shrunk pair if room and not present
      logic publish;   // load the result registers
   } pft_cmd_type;

endpackage

// ----- hdl/pft_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pft_ram #(
   parameter int WIDTH  = 80,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/pft_ctrl.sv -----
// Controller of the filter table: sequences init, prep, table scan, insert
// and result strobe. Depends on pft_pkg.
module pft_ctrl #(
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [1:0]                 req_opcode,
   output logic                       busy,
   output logic                       rsp_valid,
   output pft_pkg::pft_cmd_type       cmd,
   output logic [$clog2(ENTRIES)-1:0] rd_addr
);
   import pft_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP_MUL,
      S_PREP_SAT,
      S_SCAN,
      S_DRAIN,
      S_INSERT,
      S_INIT,
      S_FINISH
   } state_type;

   state_type  state_ff;
   opcode_type op_ff;
   logic [AW-1:0] addr_ff;
   logic       drain_ff;
   logic       busy_ff;
   logic       rsp_valid_ff;

   // State, scan address and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_NOP;
         addr_ff      <= '0;
         drain_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               addr_ff  <= '0;
               drain_ff <= 1'b0;
               if (start) begin
                  op_ff   <= opcode_type'(req_opcode);
                  busy_ff <= 1'b1;
                  case (opcode_type'(req_opcode))
                     OP_INIT:    state_ff <= S_INIT;
                     OP_QUERY:   state_ff <= S_SCAN;
                     OP_AUGMENT: state_ff <= S_PREP_MUL;
                     default:    state_ff <= S_FINISH;
                  endcase
               end
            end
            S_PREP_MUL: state_ff <= S_PREP_SAT;
            S_PREP_SAT: state_ff <= S_SCAN;
            S_SCAN: begin
               if (addr_ff == LAST_ADDR) begin
                  state_ff <= S_DRAIN;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            // lets the read and multiply stages empty
            S_DRAIN: begin
               if (drain_ff) begin
                  state_ff <= (op_ff == OP_AUGMENT) ? S_INSERT : S_FINISH;
               end
               drain_ff <= 1'b1;
            end
            S_INSERT: state_ff <= S_FINISH;
            S_INIT:   state_ff <= S_FINISH;
            S_FINISH: begin
               rsp_valid_ff <= 1'b1;
               busy_ff      <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Commands decoded from the state
   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == S_IDLE) && start;
      cmd.prep_mul = (state_ff == S_PREP_MUL);
      cmd.prep_sat = (state_ff == S_PREP_SAT);
      cmd.rd_en    = (state_ff == S_SCAN);
      cmd.init     = (state_ff == S_INIT);
      cmd.insert   = (state_ff == S_INSERT);
      cmd.publish  = (state_ff == S_FINISH);
   end

   assign rd_addr   = addr_ff;
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/pft_datapath.sv -----
// Datapath of the filter table: config registers, entry RAM, valid bits,
// shared margin multipliers, compare stage and result registers.
// Depends on pft_pkg and pft_ram.
module pft_datapath #(
   parameter int ENTRIES   = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pft_pkg::pft_cmd_type             cmd,
   input  logic [$clog2(ENTRIES)-1:0]       rd_addr,
   input  logic [1:0]                       req_opcode,
   input  logic [pft_pkg::VIOL_W-1:0]       req_viol,
   input  logic signed [pft_pkg::OBJ_W-1:0] req_objv,
   input  logic                             csr_we,
   input  logic [pft_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pft_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             rsp_in_filter,
   output logic                             rsp_overflow,
   output logic [$clog2(ENTRIES+1)-1:0]     rsp_entry_count
);
   import pft_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int FW = FRAC_BITS + 1;          // factor width, holds one
   localparam int PW = VIOL_W + FW;            // product width
   localparam int RW = VIOL_W + OBJ_W;         // RAM word: {viol, obj}
   localparam logic [31:0] ONE32 = 32'd1 << FRAC_BITS;

   // Configuration registers
   logic [GAMMA_W-1:0] gamma_theta_ff, gamma_f_ff;
   logic [VIOL_W-1:0]  tiny_ff, init_viol_ff;
   logic [OBJ_W-1:0]   init_obj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_theta_ff <= GAMMA_RESET;
         gamma_f_ff     <= GAMMA_RESET;
         tiny_ff        <= TINY_RESET;
         init_viol_ff   <= INIT_VIOL_RESET;
         init_obj_ff    <= INIT_OBJ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAMMA_THETA: gamma_theta_ff <= csr_wdata[GAMMA_W-1:0];
            CSR_GAMMA_F:     gamma_f_ff     <= csr_wdata[GAMMA_W-1:0];
            CSR_TINY_VIOL:   tiny_ff        <= csr_wdata[VIOL_W-1:0];
            CSR_INIT_VIOL:   init_viol_ff   <= csr_wdata[VIOL_W-1:0];
            CSR_INIT_OBJ:    init_obj_ff    <= csr_wdata[OBJ_W-1:0];
            default: ;
         endcase
      end
   end

   // Margin factors: gammas clamp at one; violation factor is one minus gamma
   logic [31:0]   gt_ext, gf_ext;
   logic [FW-1:0] gt_clamp, gf_clamp;
   logic [FW-1:0] theta_fac_ff, gf_fac_ff;

   assign gt_ext   = 32'(gamma_theta_ff);
   assign gf_ext   = 32'(gamma_f_ff);
   assign gt_clamp = (gt_ext >= ONE32) ? ONE32[FW-1:0] : gt_ext[FW-1:0];
   assign gf_clamp = (gf_ext >= ONE32) ? ONE32[FW-1:0] : gf_ext[FW-1:0];

   always_ff @(posedge clock) begin
      theta_fac_ff <= ONE32[FW-1:0] - gt_clamp;
      gf_fac_ff    <= gf_clamp;
   end

   // Transaction fields
   opcode_type              op_ff;
   logic [VIOL_W-1:0]       v_ff;
   logic signed [OBJ_W-1:0] f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NOP;
      end else if (cmd.load) begin
         op_ff <= opcode_type'(req_opcode);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff <= req_viol;
         f_ff <= req_objv;
      end
   end

   // Entry RAM
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic [AW-1:0] free_idx_ff;
   logic          free_found_ff, dup_ff;
   logic [VIOL_W-1:0]       nv_ff;
   logic signed [OBJ_W-1:0] no_ff;

   assign ram_we    = cmd.init || (cmd.insert && !dup_ff && free_found_ff);
   assign ram_waddr = cmd.init ? '0 : free_idx_ff;
   assign ram_wdata = cmd.init ? {init_viol_ff, init_obj_ff} : {nv_ff, no_ff};

   pft_ram #(
      .WIDTH (RW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.rd_en),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // Read stage tag
   logic          p1_valid_ff;
   logic [AW-1:0] p1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.rd_en;
      end
      p1_idx_ff <= rd_addr;
   end

   // Shared multipliers: trial violation during prep, entry violation in scan
   logic [VIOL_W-1:0] mul_x;
   logic [PW-1:0]     prod_s_ff, prod_m_ff;
   logic              p2_valid_ff;
   logic [AW-1:0]     p2_idx_ff;
   logic [VIOL_W-1:0] ev2_ff;
   logic signed [OBJ_W-1:0] eo2_ff;

   assign mul_x = cmd.prep_mul ? v_ff : ram_rdata[RW-1:OBJ_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_idx_ff <= p1_idx_ff;
      ev2_ff    <= ram_rdata[RW-1:OBJ_W];
      eo2_ff    <= ram_rdata[OBJ_W-1:0];
      prod_s_ff <= {{VIOL_W{1'b0}}, theta_fac_ff} * {{FW{1'b0}}, mul_x};
      prod_m_ff <= {{VIOL_W{1'b0}}, gf_fac_ff} * {{FW{1'b0}}, mul_x};
   end

   logic [VIOL_W-1:0] scaled_p, margin_p;
   assign scaled_p = prod_s_ff[FRAC_BITS +: VIOL_W];
   assign margin_p = prod_m_ff[FRAC_BITS +: VIOL_W];

   // Shrunk pair; the objective saturates at the most negative value
   logic signed [OBJ_W:0] no_diff;
   assign no_diff = $signed({f_ff[OBJ_W-1], f_ff}) - $signed({1'b0, 16'd0, margin_p});

   always_ff @(posedge clock) begin
      if (cmd.prep_sat) begin
         nv_ff <= scaled_p;
         if (no_diff[OBJ_W:OBJ_W-1] == 2'b10) begin
            no_ff <= INIT_OBJ_RESET;
         end else begin
            no_ff <= no_diff[OBJ_W-1:0];
         end
      end
   end

   // Compare stage
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  hit_ff, ovf_ff;
   logic                  ent_valid, vcond, ocond, dom, prune, dup, free;
   logic signed [OBJ_W:0] obj_thr;

   assign ent_valid = p2_valid_ff && valid_ff[p2_idx_ff];
   assign vcond     = (v_ff >= scaled_p) || ((v_ff < tiny_ff) && (ev2_ff < tiny_ff));
   assign obj_thr   = $signed({eo2_ff[OBJ_W-1], eo2_ff})
                    - $signed({1'b0, 16'd0, margin_p});
   assign ocond     = $signed({f_ff[OBJ_W-1], f_ff}) >= obj_thr;
   assign dom       = ent_valid && (op_ff == OP_QUERY) && vcond && ocond;
   assign prune     = ent_valid && (op_ff == OP_AUGMENT)
                    && (ev2_ff > nv_ff) && (eo2_ff > no_ff);
   assign dup       = ent_valid && (op_ff == OP_AUGMENT) && !prune
                    && (ev2_ff == nv_ff) && (eo2_ff == no_ff);
   assign free      = p2_valid_ff && (op_ff == OP_AUGMENT) && (!ent_valid || prune);

   // Valid bits and count: init, prune, insert never share a cycle
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (cmd.init) begin
         valid_in    = '0;
         valid_in[0] = 1'b1;
         count_in    = CW'(1);
      end else if (prune) begin
         valid_in[p2_idx_ff] = 1'b0;
         count_in            = count_ff - 1'b1;
      end else if (cmd.insert && !dup_ff && free_found_ff) begin
         valid_in[free_idx_ff] = 1'b1;
         count_in              = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         hit_ff        <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         if (cmd.load) begin
            hit_ff        <= 1'b0;
            dup_ff        <= 1'b0;
            free_found_ff <= 1'b0;
            ovf_ff        <= 1'b0;
         end else begin
            if (dom) begin
               hit_ff <= 1'b1;
            end
            if (dup) begin
               dup_ff <= 1'b1;
            end
            // lowest free slot wins
            if (free && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
            if (cmd.insert && !dup_ff && !free_found_ff) begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free && !free_found_ff) begin
         free_idx_ff <= p2_idx_ff;
      end
   end

   // Result registers
   logic          rsp_hit_ff, rsp_ovf_ff;
   logic [CW-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_hit_ff   <= hit_ff;
         rsp_ovf_ff   <= ovf_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_in_filter   = rsp_hit_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ----- hdl/pareto_filter_table.sv -----
// Top level of the filter dominance table: controller plus datapath.
// Depends on pft_pkg, pft_ctrl, pft_datapath (and pft_ram below it).
//
// Use: drive req_opcode, req_viol, req_objv and raise start; the command
// is taken at the clock edge where start is high and busy is low. busy
// rises in the next cycle and falls together with the rsp_valid strobe.
// Each command gives one result, shown on the rsp_ ports while rsp_valid
// is high for exactly one cycle; the receiver cannot hold it off.
// Query and augment read every table entry once through the
// single read port of the entry RAM, then one multiply-compare stage; the
// next command can be taken in the strobe cycle.
// The csr_ port writes a register at any edge with csr_we high; write only
// while busy is low. Reset clears the table to empty and the registers to
// their defaults.
module pareto_filter_table #(
   parameter int ENTRIES   = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [pft_pkg::VIOL_W-1:0]       req_viol,
   input  logic signed [pft_pkg::OBJ_W-1:0] req_objv,
   output logic                             rsp_valid,
   output logic                             rsp_in_filter,
   output logic                             rsp_overflow,
   output logic [$clog2(ENTRIES+1)-1:0]     rsp_entry_count,
   input  logic                             csr_we,
   input  logic [pft_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pft_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pft_pkg::*;

   pft_cmd_type               cmd;
   logic [$clog2(ENTRIES)-1:0] rd_addr;

   pft_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   pft_datapath #(
      .ENTRIES   (ENTRIES),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .req_opcode      (req_opcode),
      .req_viol        (req_viol),
      .req_objv        (req_objv),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_in_filter   (rsp_in_filter),
      .rsp_overflow    (rsp_overflow),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ----- hdl/pft_checker.sv -----
// Port-level checks of the filter table and the bind that attaches them.
// Depends on pareto_filter_table_assert.svh and pareto_filter_table.
`include "pareto_filter_table_assert.svh"

module pft_checker #(
   parameter int ENTRIES = 64
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_in_filter,
   input logic                         rsp_overflow,
   input logic [$clog2(ENTRIES+1)-1:0] rsp_entry_count
);

   localparam int CW = $clog2(ENTRIES + 1);

   // an accepted command always occupies the block
   `PFT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   // result strobe lasts one cycle
   `PFT_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "rsp_valid held")
   // result comes with the block free again
   `PFT_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_valid, !busy, "rsp_valid while busy")
   // count never exceeds the table size
   `PFT_ASSERT_SAME(a_count_range, clock, reset, rsp_valid, rsp_entry_count <= CW'(ENTRIES), "count too large")
   // a hit never comes with an overflow report
   `PFT_ASSERT_SAME(a_flag_excl, clock, reset, rsp_valid && rsp_in_filter, !rsp_overflow, "hit and overflow")

endmodule

bind pareto_filter_table pft_checker #(
   .ENTRIES (ENTRIES)
) u_pft_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_in_filter   (rsp_in_filter),
   .rsp_overflow    (rsp_overflow),
   .rsp_entry_count (rsp_entry_count)
);

// ----- dv/tb_pareto_filter_table.sv -----
// Self-checking testbench for the pareto_filter_table dominance filter.
// Depends on pft_pkg and pareto_filter_table. Filter commands are checked against an
// in-bench mirror of the table across several CSR settings.
module tb_pareto_filter_table;
   timeunit 1ns;
   timeprecision 1ps;

   import pft_pkg::*;

   localparam int              ENTRIES      = 64;
   localparam int              FRAC         = 16;
   localparam longint unsigned ONE_FX       = 64'd1 << FRAC;
   localparam longint          OBJ_MAX      = 64'sd140737488355327;
   localparam longint          OBJ_MIN      = -64'sd140737488355328;
   localparam logic [47:0]     OBJV_MAX     = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0]     OBJV_MIN     = 48'h8000_0000_0000;
   localparam int              PHASES       = 6;
   localparam int              PHASE_OPS    = 125;
   localparam int              DRAIN_CYCLES = 80;
   localparam int              CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic       in_filter;
      logic       overflow;
      logic [6:0] entry_count;
   } verdict_type;

   typedef struct {
      opcode_type  op;
      logic [31:0] viol;
      logic [47:0] objv;
      bit          typed;
      verdict_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = 2'd0;
   logic [VIOL_W-1:0] req_viol = '0;
   logic signed [OBJ_W-1:0] req_objv = '0;
   logic        rsp_valid;
   logic        rsp_in_filter;
   logic        rsp_overflow;
   logic [6:0]  rsp_entry_count;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pareto_filter_table #(.ENTRIES(ENTRIES), .FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_viol(req_viol), .req_objv(req_objv),
      .rsp_valid(rsp_valid), .rsp_in_filter(rsp_in_filter),
      .rsp_overflow(rsp_overflow), .rsp_entry_count(rsp_entry_count),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the filter table and its CSRs
   bit              mirror_valid [ENTRIES];
   longint unsigned mirror_viol  [ENTRIES];
   longint          mirror_obj   [ENTRIES];
   int unsigned     mirror_count;
   longint unsigned cfg_gamma_theta = GAMMA_RESET;
   longint unsigned cfg_gamma_f     = GAMMA_RESET;
   longint unsigned cfg_tiny        = TINY_RESET;
   longint unsigned cfg_init_viol   = INIT_VIOL_RESET;
   longint          cfg_init_obj    = OBJ_MIN;

   verdict_type verdict_q [$];
   int          mismatches = 0;
   int          burst_left = 0;
   int          random_ops = 0;
   int          cycle_count = 0;

   function automatic longint unsigned clamp_gamma(longint unsigned g);
      return (g >= ONE_FX) ? ONE_FX : g;
   endfunction

   function automatic longint unsigned shrink_viol(longint unsigned v);
      return ((ONE_FX - clamp_gamma(cfg_gamma_theta)) * v) >> FRAC;
   endfunction

   function automatic longint unsigned obj_margin(longint unsigned v);
      return (clamp_gamma(cfg_gamma_f) * v) >> FRAC;
   endfunction

   function automatic bit is_dominated(longint unsigned v, longint f);
      bit vcond;
      for (int i = 0; i < ENTRIES; i++) begin
         if (mirror_valid[i]) begin
            vcond = (v >= shrink_viol(mirror_viol[i])) ||
                    (v < cfg_tiny && mirror_viol[i] < cfg_tiny);
            if (vcond && f >= mirror_obj[i] - longint'(obj_margin(mirror_viol[i])))
               return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Returns 1 when the shrunk pair is dropped for lack of room
   function automatic bit add_pair(longint unsigned v, longint f);
      longint unsigned nv;
      longint          no;
      int              free_slot;
      nv = shrink_viol(v);
      no = f - longint'(obj_margin(v));
      free_slot = -1;
      if (no < OBJ_MIN) no = OBJ_MIN;
      // prune entries strictly worse in both coordinates
      for (int i = 0; i < ENTRIES; i++) begin
         if (mirror_valid[i] && mirror_viol[i] > nv && mirror_obj[i] > no) begin
            mirror_valid[i] = 1'b0;
            mirror_count--;
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (mirror_valid[i]) begin
            if (mirror_viol[i] == nv && mirror_obj[i] == no) return 1'b0;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (free_slot < 0) return 1'b1;
      mirror_valid[free_slot] = 1'b1;
      mirror_viol[free_slot]  = nv;
      mirror_obj[free_slot]   = no;
      mirror_count++;
      return 1'b0;
   endfunction

   // Advances the mirror by one command and returns its verdict
   function automatic verdict_type apply_filter_op(opcode_type op, logic [31:0] v,
                                                   logic [47:0] f);
      verdict_type r;
      longint      fs;
      r  = '0;
      fs = $signed(f);
      case (op)
         OP_INIT: begin
            foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;
            mirror_valid[0] = 1'b1;
            mirror_viol[0]  = cfg_init_viol;
            mirror_obj[0]   = cfg_init_obj;
            mirror_count    = 1;
         end
         OP_QUERY:   r.in_filter = is_dominated(v, fs);
         OP_AUGMENT: r.overflow  = add_pair(v, fs);
         default: ;
      endcase
      r.entry_count = 7'(mirror_count);
      return r;
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[47:0];
   endfunction

   function automatic stim_row_type make_row(opcode_type op, logic [31:0] v, logic [47:0] f,
                                             bit typed, bit hit, bit ovf, int cnt);
      stim_row_type r;
      r.op = op;
      r.viol = v;
      r.objv = f;
      r.typed = typed;
      r.want.in_filter = hit;
      r.want.overflow = ovf;
      r.want.entry_count = 7'(cnt);
      return r;
   endfunction

   // Trial pair close to the dominance boundary of a random valid entry, or a random pair if none is valid
   function automatic void near_query(output logic [31:0] v, output logic [47:0] f);
      int     idx;
      int     dv;
      int     df;
      longint tv;
      longint tf;
      idx = -1;
      dv = int'($urandom_range(0, 4)) - 2;
      df = int'($urandom_range(0, 4)) - 2;
      for (int k = 0, j = $urandom_range(0, ENTRIES - 1); k < ENTRIES; k++) begin
         if (idx < 0 && mirror_valid[(j + k) % ENTRIES]) idx = (j + k) % ENTRIES;
      end
      if (idx < 0) begin
         v = $urandom();
         f = rand48();
         return;
      end
      tv = longint'(shrink_viol(mirror_viol[idx])) + dv;
      if ($urandom_range(0, 3) == 0) tv = longint'(cfg_tiny) - $urandom_range(0, 1);
      if (tv < 0) tv = 0;
      if (tv > 64'sd4294967295) tv = 64'sd4294967295;
      tf = mirror_obj[idx] - longint'(obj_margin(mirror_viol[idx])) + df;
      if (tf < OBJ_MIN) tf = OBJ_MIN;
      if (tf > OBJ_MAX) tf = OBJ_MAX;
      v = tv[31:0];
      f = tf[47:0];
      if ($urandom_range(0, 4) == 0) v = $urandom();
      if ($urandom_range(0, 4) == 0) f = rand48();
   endfunction

   // Let the table finish every outstanding transaction
   task automatic wait_for_verdicts();
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Issue one command, record its verdict, then pace the sender in bursts
   task automatic run_op(input opcode_type op, input logic [31:0] v, input logic [47:0] f,
                         input bit typed, input verdict_type typed_want);
      verdict_type want;
      req_opcode <= op;
      req_viol   <= v;
      req_objv   <= f;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      want = apply_filter_op(op, v, f);
      verdict_q.push_back(typed ? typed_want : want);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if ($urandom_range(0, 19) == 0) begin
            wait_for_verdicts();
         end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clock);
         end
      end
   endtask

   task automatic write_config(input logic [15:0] gt, input logic [15:0] gf,
                               input logic [31:0] tiny, input logic [31:0] iv,
                               input logic [47:0] io);
      csr_we    <= 1'b1;
      csr_index <= CSR_GAMMA_THETA;
      csr_wdata <= CSR_DATA_W'(gt);
      @(posedge clock);
      csr_index <= CSR_GAMMA_F;
      csr_wdata <= CSR_DATA_W'(gf);
      @(posedge clock);
      csr_index <= CSR_TINY_VIOL;
      csr_wdata <= CSR_DATA_W'(tiny);
      @(posedge clock);
      csr_index <= CSR_INIT_VIOL;
      csr_wdata <= CSR_DATA_W'(iv);
      @(posedge clock);
      csr_index <= CSR_INIT_OBJ;
      csr_wdata <= io;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_gamma_theta = gt;
      cfg_gamma_f     = gf;
      cfg_tiny        = tiny;
      cfg_init_viol   = iv;
      cfg_init_obj    = $signed(io);
   endtask

   // One init followed by a monotone front: violation rising, objective falling.
   // A front-building episode keeps noise from pruning so the table can fill up.
   task automatic run_episode(input int n_ops, input bit building);
      longint unsigned front_v;
      longint          front_f;
      logic [31:0]     last_v;
      logic [47:0]     last_f;
      logic [31:0]     qv;
      logic [47:0]     qf;
      opcode_type      op;
      int              pick;
      int              aug_pct;
      aug_pct = building ? 85 : 55;
      front_v = $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 32'h7FFF_FFFF);
      front_f = {$urandom_range(0, 32'h3FFF), $urandom()};
      if ($urandom_range(0, 1)) front_f = front_f - (64'sd1 <<< 45);
      last_v = front_v[31:0];
      last_f = front_f[47:0];
      run_op(OP_INIT, $urandom(), rand48(), 1'b0, '0);
      random_ops++;
      for (int n = 1; n < n_ops; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            run_op(OP_AUGMENT, last_v, last_f, 1'b0, '0);
         end else if (pick < aug_pct) begin
            front_v = front_v + $urandom_range(1, 32'h0100_0000);
            if (front_v > 64'hFFFF_FFFF) front_v = 64'hFFFF_FFFF;
            front_f = front_f - longint'({$urandom_range(0, 63), $urandom()});
            last_v = front_v[31:0];
            last_f = front_f[47:0];
            run_op(OP_AUGMENT, last_v, last_f, 1'b0, '0);
         end else if (pick < aug_pct + 30) begin
            near_query(qv, qf);
            run_op(OP_QUERY, qv, qf, 1'b0, '0);
         end else begin
            op = opcode_type'($urandom_range(0, 3));
            if (building && (op == OP_INIT || op == OP_AUGMENT)) op = OP_QUERY;
            run_op(op, $urandom(), rand48(), 1'b0, '0);
         end
         random_ops++;
      end
   endtask

   // Result checking
   task automatic report(input string field, input longint unsigned want,
                         input longint unsigned got);
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            report("unexpected transaction, entry_count", 0, rsp_entry_count);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_in_filter !== want.in_filter)
               report("in_filter", want.in_filter, rsp_in_filter);
            if (rsp_overflow !== want.overflow)
               report("overflow", want.overflow, rsp_overflow);
            if (rsp_entry_count !== want.entry_count)
               report("entry_count", want.entry_count, rsp_entry_count);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions outstanding",
                  cycle_count, verdict_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      int           target;
      int           ep_len;
      bit           building;
      foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;
      mirror_count = 0;

      // Directed rows; the easy ones carry their verdict inline
      rows.push_back(make_row(OP_NOP,     32'h1234_5678, 48'h0,     1, 0, 0, 0));
      rows.push_back(make_row(OP_QUERY,   32'h0,         OBJV_MIN,  1, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'h0000_1000, 48'h1000,  0, 0, 0, 0));
      rows.push_back(make_row(OP_INIT,    32'hFFFF_FFFF, '1,        1, 0, 0, 1));
      rows.push_back(make_row(OP_QUERY,   32'hFFFF_FFFF, OBJV_MAX,  1, 1, 0, 1));
      rows.push_back(make_row(OP_QUERY,   32'h0,         OBJV_MIN,  1, 0, 0, 1));
      rows.push_back(make_row(OP_AUGMENT, 32'h0,         OBJV_MAX,  0, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'h0,         OBJV_MAX,  0, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'hFFFF_FFFF, OBJV_MIN,  0, 0, 0, 0));
      rows.push_back(make_row(OP_QUERY,   32'h0,         48'h0,     0, 0, 0, 0));
      rows.push_back(make_row(OP_QUERY,   32'hFFFF_FFFF, OBJV_MIN,  0, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'h0001_0000, 48'h0,     0, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'h0000_0001, OBJV_MIN + 1, 0, 0, 0, 0));
      rows.push_back(make_row(OP_NOP,     32'hFFFF_FFFF, OBJV_MAX,  0, 0, 0, 0));
      rows.push_back(make_row(OP_QUERY,   32'h0000_FFFF, 48'h7FFF_0000_0000, 0, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'h8000_0000, OBJV_MIN,  0, 0, 0, 0));
      rows.push_back(make_row(OP_AUGMENT, 32'h0,         OBJV_MIN,  0, 0, 0, 0));
      rows.push_back(make_row(OP_QUERY,   32'h0,         OBJV_MIN,  0, 0, 0, 0));
      rows.push_back(make_row(OP_INIT,    32'h0,         48'h0,     1, 0, 0, 1));
      rows.push_back(make_row(OP_NOP,     32'h0,         48'h0,     1, 0, 0, 1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) run_op(rows[i].op, rows[i].viol, rows[i].objv, rows[i].typed,
                               rows[i].want);

      // Random phases; the first keeps the reset CSR values
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_verdicts();
         case (phase)
            0: ;
            1: write_config(16'd0, 16'd0, 32'd0, 32'd0, OBJV_MAX);
            2: write_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OBJV_MIN);
            default: write_config($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 2000),
                                  $urandom_range(0, 65535), $urandom_range(0, 32'h0010_0000),
                                  $urandom(), rand48());
         endcase
         target = random_ops + PHASE_OPS;
         while (random_ops < target) begin
            building = ($urandom_range(0, 9) < 4);
            ep_len = building ? $urandom_range(90, 110) : $urandom_range(5, 30);
            // the last episode of a phase stops at the phase budget
            if (ep_len > target - random_ops) ep_len = target - random_ops;
            run_episode(ep_len, building);
         end
      end

      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/pft_pkg.sv
hdl/pft_ram.sv
hdl/pft_ctrl.sv
hdl/pft_datapath.sv
hdl/pareto_filter_table.sv
hdl/pft_checker.sv
dv/tb_pareto_filter_table.sv
